@@ hdl/assert_macros.svh @@
// assertion macros used by gnss_nav_word_encoder_unit
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hdl/gnw_pkg.sv @@
// constants and encoding functions of the navigation word encoder
// gps lnav hamming parity, beidou d1 bch(15,11) and interleave; no dependencies
package gnw_pkg;

    localparam int WORDS_PER_SUBFRAME = 10;

    localparam logic SYS_GPS = 1'b0;
    localparam logic SYS_BDS = 1'b1;

    localparam logic [3:0] WORD_FIRST = 4'd0;
    localparam logic [3:0] WORD_TIME  = 4'd1;
    localparam logic [3:0] WORD_WEEK  = 4'd2;
    localparam logic [3:0] WORD_LAST  = 4'(WORDS_PER_SUBFRAME - 1);

    localparam logic [2:0] SUBFRAME_WEEK = 3'd0;

    localparam logic [29:0] DATA_MASK = 30'h3FFFFFC0;

    localparam logic [29:0] PARITY_MASK [6] = '{
        30'h3B1F3480, 30'h1D8F9A40, 30'h2EC7CD00,
        30'h1763E680, 30'h2BB1F340, 30'h0B7A89C0
    };

    // x^(i+4) mod x^4 + x + 1, one entry per info bit
    localparam logic [3:0] BCH_REM [11] = '{
        4'h3, 4'h6, 4'hC, 4'hB, 4'h5, 4'hA,
        4'h7, 4'hE, 4'hF, 4'hD, 4'h9
    };

    function automatic logic [29:0] gps_encode(input logic [29:0] w, input logic solve_bits,
                                               input logic [1:0] tail);
        logic [29:0] d;
        logic [29:0] r;
        logic p29;
        logic p30;
        d   = w & DATA_MASK;
        p29 = tail[1];
        p30 = tail[0];
        if (solve_bits)
        begin
            if (p30 ^ (^(PARITY_MASK[4] & d)))
                d[6] = ~d[6];
            if (p29 ^ (^(PARITY_MASK[5] & d)))
                d[7] = ~d[7];
        end
        r    = p30 ? (d ^ DATA_MASK) : d;
        r[5] = p29 ^ (^(PARITY_MASK[0] & d));
        r[4] = p30 ^ (^(PARITY_MASK[1] & d));
        r[3] = p29 ^ (^(PARITY_MASK[2] & d));
        r[2] = p30 ^ (^(PARITY_MASK[3] & d));
        r[1] = p30 ^ (^(PARITY_MASK[4] & d));
        r[0] = p29 ^ (^(PARITY_MASK[5] & d));
        return r;
    endfunction

    function automatic logic [14:0] bch15(input logic [10:0] info);
        logic [3:0] chk;
        chk = 4'h0;
        for (int i = 0; i < 11; i++)
        begin
            if (info[i])
                chk = chk ^ BCH_REM[i];
        end
        return {info, chk};
    endfunction

    function automatic logic [29:0] weave(input logic [14:0] lo, input logic [14:0] hi);
        logic [29:0] r;
        r = '0;
        for (int i = 0; i < 15; i++)
        begin
            r[2 * i]     = lo[i];
            r[2 * i + 1] = hi[i];
        end
        return r;
    endfunction

    function automatic logic [29:0] gps_insert(input logic [29:0] w, input logic [3:0] widx,
                                               input logic [2:0] sidx,
                                               input logic [19:0] tc,
                                               input logic [12:0] week);
        logic [29:0] x;
        x = w;
        if (widx == WORD_TIME)
            x[29:13] = x[29:13] | tc[16:0];
        if (sidx == SUBFRAME_WEEK && widx == WORD_WEEK)
            x[29:20] = x[29:20] | week[9:0];
        return x;
    endfunction

    function automatic logic [29:0] bds_encode(input logic [29:0] w, input logic [3:0] widx,
                                               input logic [2:0] sidx,
                                               input logic [19:0] tc,
                                               input logic [12:0] week);
        logic [29:0] x;
        logic [29:0] r;
        x = w;
        if (sidx == SUBFRAME_WEEK && widx == WORD_WEEK)
            x = {8'h00, week, w[8:0]};
        if (widx == WORD_FIRST)
            x = {x[29:12], tc[19:12], 4'h0};
        else if (widx == WORD_TIME)
            x = {8'h00, tc[11:0], x[9:0]};
        if (widx == WORD_FIRST)
            r = {x[29:15], bch15(x[14:4])};
        else
            r = weave(bch15(x[10:0]), bch15(x[21:11]));
        return r;
    endfunction

endpackage

@@ hdl/gnss_nav_word_encoder_unit.sv @@
// Encodes one raw navigation word per transfer into its 30-bit transmitted form: GPS LNAV
// parity with D29/D30 chaining, or BeiDou D1 BCH(15,11), interleaved after the first word,
// chosen by the system bit written through cfg_we/cfg_wdata. A word passes an input
// register and an output register; it moves on to the output register whenever that
// register is empty or not stalled. A new word is taken every cycle, and the input stalls
// only while both registers hold words and the output is stalled. The only state between
// words is the two tail bits, updated in the same cycle a word moves from the input
// register into the output register. Depends on gnw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gnss_nav_word_encoder_unit
    import gnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [29:0] raw_word,
    input  logic [3:0]  word_index,
    input  logic [2:0]  subframe_index,
    input  logic [19:0] time_count,
    input  logic [12:0] week_number,
    input  logic        restart_chain,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] encoded_word
);

    logic        sys_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [29:0] s1_word_reg;
    logic [3:0]  s1_widx_reg;
    logic [2:0]  s1_sidx_reg;
    logic [19:0] s1_time_reg;
    logic [12:0] s1_week_reg;
    logic        s1_restart_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [29:0] encoded_word_reg;
    logic [29:0] encoded_word_next;
    logic [1:0]  tail_reg;
    logic [1:0]  tail_next;
    logic [1:0]  tail_used;
    logic        s2_load;
    logic        in_xfer;
    logic        advance;
    logic        solve_bits;

    assign s2_load  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_xfer  = in_valid && !in_stall;
    assign advance  = s1_valid_reg && s2_load;

    assign out_valid    = out_valid_reg;
    assign encoded_word = encoded_word_reg;

    assign tail_used  = s1_restart_reg ? 2'b00 : tail_reg;
    assign solve_bits = (s1_widx_reg == WORD_TIME) || (s1_widx_reg == WORD_LAST);

    always_comb
    begin
        if (sys_reg == SYS_GPS)
            encoded_word_next = gps_encode(gps_insert(s1_word_reg, s1_widx_reg, s1_sidx_reg,
                                                      s1_time_reg, s1_week_reg),
                                           solve_bits, tail_used);
        else
            encoded_word_next = bds_encode(s1_word_reg, s1_widx_reg, s1_sidx_reg,
                                           s1_time_reg, s1_week_reg);
    end

    always_comb
    begin
        tail_next = tail_reg;
        if (advance)
        begin
            if (sys_reg == SYS_GPS)
                tail_next = encoded_word_next[1:0];
            else
                tail_next = tail_used;
        end
    end

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s2_load);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_reg       <= SYS_GPS;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tail_reg      <= 2'b00;
        end
        else
        begin
            if (cfg_we)
                sys_reg <= cfg_wdata;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_word_reg    <= raw_word;
            s1_widx_reg    <= word_index;
            s1_sidx_reg    <= subframe_index;
            s1_time_reg    <= time_count;
            s1_week_reg    <= week_number;
            s1_restart_reg <= restart_chain;
        end
        if (advance)
            encoded_word_reg <= encoded_word_next;
    end

    `ASSERT_ALWAYS(a_stall_needs_word, clk, rst_n, in_stall |-> s1_valid_reg)
    `ASSERT_ALWAYS(a_gps_tail_follows, clk, rst_n, (advance && sys_reg == SYS_GPS) |=> (tail_reg == encoded_word_reg[1:0]))
    `ASSERT_ALWAYS(a_bds_tail_holds, clk, rst_n, (advance && sys_reg == SYS_BDS && !s1_restart_reg) |=> $stable(tail_reg))
    `ASSERT_ALWAYS(a_out_from_stage, clk, rst_n, $rose(out_valid_reg) |-> $past(s1_valid_reg))

endmodule
